// ----- hw/rtl/qes_pkg.sv -----
// Package: shared types, codes and constants of the quaternion steering block.
`timescale 1ns / 1ps
package qes_pkg;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_POSE   = 2'd1;
  localparam logic [1:0] KIND_UNPAIR = 2'd2;

  localparam logic [2:0] POSE_REST    = 3'd0;
  localparam logic [2:0] POSE_FIST    = 3'd1;
  localparam logic [2:0] POSE_WAVEOUT = 3'd3;
  localparam logic [2:0] POSE_SPREAD  = 3'd4;
  localparam logic [2:0] POSE_UNKNOWN = 3'd6;
  localparam logic [2:0] POSE_INVALID = 3'd7;

  localparam logic [1:0] DRIVE_NONE    = 2'd0;
  localparam logic [1:0] DRIVE_FORWARD = 2'd1;
  localparam logic [1:0] DRIVE_REVERSE = 2'd2;

  localparam logic [1:0] STEER_NONE     = 2'd0;
  localparam logic [1:0] STEER_RIGHT    = 2'd1;
  localparam logic [1:0] STEER_LEFT     = 2'd2;
  localparam logic [1:0] STEER_STRAIGHT = 2'd3;

  localparam logic [1:0] UNLOCK_NONE  = 2'd0;
  localparam logic [1:0] UNLOCK_TIMED = 2'd1;
  localparam logic [1:0] UNLOCK_HOLD  = 2'd2;

  localparam logic [2:0] REG_RIGHT_LOW  = 3'd0;
  localparam logic [2:0] REG_RIGHT_HIGH = 3'd1;
  localparam logic [2:0] REG_LEFT_LOW   = 3'd2;
  localparam logic [2:0] REG_LEFT_HIGH  = 3'd3;

  localparam logic [1:0] SEL_ROLL  = 2'd0;
  localparam logic [1:0] SEL_PITCH = 2'd1;
  localparam logic [1:0] SEL_YAW   = 2'd2;

  localparam logic [4:0] MUL_LAST_TERM = 5'd8;
  localparam logic [4:0] MUL_LAST_SQ   = 5'd11;
  localparam logic [4:0] SQRT_TOP      = 5'd28;

  localparam logic signed [35:0] ONE_Q28      = 36'sd268435456;
  localparam logic signed [26:0] HALF_TURN    = 27'sd8388608;
  localparam logic signed [26:0] QUARTER_TURN = 27'sd4194304;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       clamp;
    logic       sqrt;
    logic       cinit;
    logic       cstep;
    logic       cbin;
    logic       commit;
    logic [4:0] idx;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
  } status_t;

  function automatic logic [21:0] atan_units(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:  v = 22'd2097152;
      5'd1:  v = 22'd1238021;
      5'd2:  v = 22'd654136;
      5'd3:  v = 22'd332050;
      5'd4:  v = 22'd166669;
      5'd5:  v = 22'd83416;
      5'd6:  v = 22'd41718;
      5'd7:  v = 22'd20860;
      5'd8:  v = 22'd10430;
      5'd9:  v = 22'd5215;
      5'd10: v = 22'd2608;
      5'd11: v = 22'd1304;
      5'd12: v = 22'd652;
      5'd13: v = 22'd326;
      5'd14: v = 22'd163;
      5'd15: v = 22'd81;
      5'd16: v = 22'd41;
      5'd17: v = 22'd20;
      5'd18: v = 22'd10;
      5'd19: v = 22'd5;
      5'd20: v = 22'd3;
      5'd21: v = 22'd1;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/quaternion_euler_steering.sv -----
// Top level: quaternion to Euler-angle bins and gesture steering commands.
`timescale 1ns / 1ps
// One request at a time. An orientation sample runs nine products and a
// three-part square of the pitch term on one shared 17x17 multiplier, a
// one-bit-per-cycle square root, and three runs of one shared CORDIC stage.
// Pose, unpair and other kinds skip these phases. The finished result sits in
// an output register, so the next request is taken while it waits. Config
// writes are always ready and must come only while the block is idle.
module quaternion_euler_steering
  import qes_pkg::*;
#(
  parameter int ANGLE_BINS   = 18,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic [2:0]         in_pose_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_roll_bin,
  output logic [4:0]         out_pitch_bin,
  output logic [4:0]         out_yaw_bin,
  output logic [1:0]         out_drive,
  output logic [1:0]         out_steer,
  output logic [1:0]         out_unlock_action,
  output logic               out_notify,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [4:0]         cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  qes_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  qes_datapath #(.ANGLE_BINS(ANGLE_BINS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_kind          (in_kind),
    .in_quat_w        (in_quat_w),
    .in_quat_x        (in_quat_x),
    .in_quat_y        (in_quat_y),
    .in_quat_z        (in_quat_z),
    .in_pose_code     (in_pose_code),
    .cfg_we           (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_roll_bin     (out_roll_bin),
    .out_pitch_bin    (out_pitch_bin),
    .out_yaw_bin      (out_yaw_bin),
    .out_drive        (out_drive),
    .out_steer        (out_steer),
    .out_unlock_action(out_unlock_action),
    .out_notify       (out_notify)
  );

endmodule

// ----- hw/rtl/qes_ctrl.sv -----
// Controller: sequences multiply, square root, CORDIC and result phases.
`timescale 1ns / 1ps
module qes_ctrl
  import qes_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_CLAMP = 9'b000000100,
    S_SQ    = 9'b000001000,
    S_SQRT  = 9'b000010000,
    S_CINIT = 9'b000100000,
    S_CSTEP = 9'b001000000,
    S_CBIN  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  localparam logic [4:0] STEP_LAST = 5'(CORDIC_STEPS - 1);

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.idx       = cnt_r;
    cmd.sel       = sel_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          sel_nxt  = SEL_ROLL;
          state_nxt = (status.kind == KIND_SAMPLE) ? S_MUL : S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == MUL_LAST_TERM) state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.mul = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == MUL_LAST_SQ) begin
          cnt_nxt   = SQRT_TOP;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        cnt_nxt  = cnt_r - 5'd1;
        if (cnt_r == '0) state_nxt = S_CINIT;
      end
      S_CINIT: begin
        cmd.cinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_CSTEP;
      end
      S_CSTEP: begin
        cmd.cstep = 1'b1;
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r == STEP_LAST) state_nxt = S_CBIN;
      end
      S_CBIN: begin
        cmd.cbin = 1'b1;
        sel_nxt  = sel_r + 2'd1;
        state_nxt = (sel_r == SEL_YAW) ? S_OUT : S_CINIT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= SEL_ROLL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/qes_datapath.sv -----
// Datapath: shared multiplier, square root, CORDIC unit, stores and result registers.
`timescale 1ns / 1ps
module qes_datapath
  import qes_pkg::*;
#(
  parameter int ANGLE_BINS = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic [2:0]         in_pose_code,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  output logic [4:0]         out_roll_bin,
  output logic [4:0]         out_pitch_bin,
  output logic [4:0]         out_yaw_bin,
  output logic [1:0]         out_drive,
  output logic [1:0]         out_steer,
  output logic [1:0]         out_unlock_action,
  output logic               out_notify
);

  localparam logic [4:0]  BINS   = 5'(ANGLE_BINS);
  localparam logic [31:0] BINS_W = 32'(ANGLE_BINS);

  logic [1:0]         kind_r;
  logic [2:0]         pose_in_r;
  logic signed [15:0] w_r, x_r, y_r, z_r;
  logic signed [35:0] rn_r, rd_r, yn_r, yd_r, s_r;
  logic [57:0]        n_r, r_r;
  logic signed [39:0] cx_r, cy_r;
  logic signed [26:0] cz_r;
  logic               zero_r;
  logic [4:0]         bin_roll_r, bin_pitch_r, bin_yaw_r;
  logic [4:0]         roll_r, pitch_r, yaw_r, rl_r, rh_r, ll_r, lh_r;
  logic [2:0]         pose_r;

  assign status.kind = cmd.load ? in_kind : kind_r;

  // shared multiplier
  logic signed [16:0] ma, mb;
  logic signed [33:0] prod;
  logic signed [35:0] p2;
  logic [28:0]        mag;
  always_comb begin
    mag = s_r[35] ? 29'(-s_r) : s_r[28:0];
    ma  = '0;
    mb  = '0;
    unique case (cmd.idx)
      5'd0:  begin ma = 17'(w_r); mb = 17'(x_r); end
      5'd1:  begin ma = 17'(y_r); mb = 17'(z_r); end
      5'd2:  begin ma = 17'(x_r); mb = 17'(x_r); end
      5'd3:  begin ma = 17'(y_r); mb = 17'(y_r); end
      5'd4:  begin ma = 17'(w_r); mb = 17'(z_r); end
      5'd5:  begin ma = 17'(x_r); mb = 17'(y_r); end
      5'd6:  begin ma = 17'(z_r); mb = 17'(z_r); end
      5'd7:  begin ma = 17'(w_r); mb = 17'(y_r); end
      5'd8:  begin ma = 17'(z_r); mb = 17'(x_r); end
      5'd9:  begin ma = {2'b0, mag[14:0]};  mb = {2'b0, mag[14:0]}; end
      5'd10: begin ma = {3'b0, mag[28:15]}; mb = {2'b0, mag[14:0]}; end
      5'd11: begin ma = {3'b0, mag[28:15]}; mb = {3'b0, mag[28:15]}; end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = ma * mb;
    p2   = {prod[33], prod, 1'b0};
  end

  // square root step
  logic [57:0] sq_b, sq_t;
  assign sq_b = 58'd1 << {cmd.idx, 1'b0};
  assign sq_t = r_r + sq_b;

  // CORDIC init and step
  logic signed [39:0] y0, x0, dx, dy;
  logic signed [26:0] da, zq, off;
  always_comb begin
    unique case (cmd.sel)
      SEL_ROLL:  begin y0 = 40'(rn_r); x0 = 40'(rd_r); end
      SEL_PITCH: begin y0 = 40'(s_r);  x0 = {11'b0, r_r[28:0]}; end
      default:   begin y0 = 40'(yn_r); x0 = 40'(yd_r); end
    endcase
    dx  = cy_r >>> cmd.idx;
    dy  = cx_r >>> cmd.idx;
    da  = {5'b0, atan_units(cmd.idx)};
    zq  = zero_r ? '0 : cz_r;
    off = zq + ((cmd.sel == SEL_PITCH) ? QUARTER_TURN : HALF_TURN);
  end

  logic [31:0] bm, bs;
  logic [4:0]  bin;
  always_comb begin
    bm  = 32'(off[25:0]) * BINS_W;
    bs  = (cmd.sel == SEL_PITCH) ? (bm >> 23) : (bm >> 24);
    if (off <= 0)         bin = '0;
    else if (bs > BINS_W) bin = BINS;
    else                  bin = bs[4:0];
  end

  // result formation
  logic [4:0] roll_nxt, pitch_nxt, yaw_nxt;
  logic [2:0] pose_nxt, pc;
  logic [1:0] unlock, drive, steer;
  logic       notify;
  always_comb begin
    roll_nxt  = roll_r;
    pitch_nxt = pitch_r;
    yaw_nxt   = yaw_r;
    pose_nxt  = pose_r;
    unlock    = UNLOCK_NONE;
    notify    = 1'b0;
    pc        = (pose_in_r == POSE_INVALID) ? POSE_UNKNOWN : pose_in_r;
    unique case (kind_r)
      KIND_SAMPLE: begin
        roll_nxt  = bin_roll_r;
        pitch_nxt = bin_pitch_r;
        yaw_nxt   = bin_yaw_r;
      end
      KIND_POSE: begin
        pose_nxt = pc;
        if (pc != POSE_REST && pc != POSE_UNKNOWN) begin
          unlock = UNLOCK_HOLD;
          notify = 1'b1;
        end else begin
          unlock = UNLOCK_TIMED;
        end
      end
      KIND_UNPAIR: begin
        roll_nxt  = '0;
        pitch_nxt = '0;
        yaw_nxt   = '0;
      end
      default: ;
    endcase
    if (pose_nxt == POSE_FIST) drive = DRIVE_FORWARD;
    else if (pose_nxt == POSE_SPREAD || pose_nxt == POSE_WAVEOUT) drive = DRIVE_REVERSE;
    else drive = DRIVE_NONE;
    if (yaw_nxt == '0) steer = STEER_STRAIGHT;
    else if (yaw_nxt > rl_r && yaw_nxt < rh_r) steer = STEER_RIGHT;
    else if (yaw_nxt > ll_r && yaw_nxt < lh_r) steer = STEER_LEFT;
    else steer = STEER_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_r  <= '0;
      pitch_r <= '0;
      yaw_r   <= '0;
      pose_r  <= POSE_UNKNOWN;
      rl_r    <= 5'd12;
      rh_r    <= 5'd16;
      ll_r    <= 5'd0;
      lh_r    <= 5'd5;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RIGHT_LOW:  rl_r <= cfg_data;
          REG_RIGHT_HIGH: rh_r <= cfg_data;
          REG_LEFT_LOW:   ll_r <= cfg_data;
          REG_LEFT_HIGH:  lh_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        roll_r  <= roll_nxt;
        pitch_r <= pitch_nxt;
        yaw_r   <= yaw_nxt;
        pose_r  <= pose_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      pose_in_r <= in_pose_code;
      w_r       <= in_quat_w;
      x_r       <= in_quat_x;
      y_r       <= in_quat_y;
      z_r       <= in_quat_z;
      rn_r      <= '0;
      rd_r      <= ONE_Q28;
      yn_r      <= '0;
      yd_r      <= ONE_Q28;
      s_r       <= '0;
    end
    if (cmd.mul) begin
      unique case (cmd.idx)
        5'd0, 5'd1: rn_r <= rn_r + p2;
        5'd2:       rd_r <= rd_r - p2;
        5'd3: begin
          rd_r <= rd_r - p2;
          yd_r <= yd_r - p2;
        end
        5'd4, 5'd5: yn_r <= yn_r + p2;
        5'd6:       yd_r <= yd_r - p2;
        5'd7:       s_r  <= s_r + p2;
        5'd8:       s_r  <= s_r - p2;
        5'd9:       n_r  <= n_r - {28'b0, prod[29:0]};
        5'd10:      n_r  <= n_r - {13'b0, prod[28:0], 16'b0};
        5'd11:      n_r  <= n_r - {prod[27:0], 30'b0};
        default: ;
      endcase
    end
    if (cmd.clamp) begin
      if (s_r > ONE_Q28) s_r <= ONE_Q28;
      else if (s_r < -ONE_Q28) s_r <= -ONE_Q28;
      n_r <= 58'd1 << 56;
      r_r <= '0;
    end
    if (cmd.sqrt) begin
      if (n_r >= sq_t) begin
        n_r <= n_r - sq_t;
        r_r <= (r_r >> 1) + sq_b;
      end else begin
        r_r <= r_r >> 1;
      end
    end
    if (cmd.cinit) begin
      zero_r <= (x0 == '0) && (y0 == '0);
      if (x0 < 0) begin
        cz_r <= (y0 >= 0) ? HALF_TURN : -HALF_TURN;
        cx_r <= -x0;
        cy_r <= -y0;
      end else begin
        cz_r <= '0;
        cx_r <= x0;
        cy_r <= y0;
      end
    end
    if (cmd.cstep) begin
      if (cy_r > 0) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + da;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - da;
      end
    end
    if (cmd.cbin) begin
      unique case (cmd.sel)
        SEL_ROLL:  bin_roll_r  <= bin;
        SEL_PITCH: bin_pitch_r <= bin;
        default:   bin_yaw_r   <= bin;
      endcase
    end
    if (cmd.commit) begin
      out_roll_bin      <= roll_nxt;
      out_pitch_bin     <= pitch_nxt;
      out_yaw_bin       <= yaw_nxt;
      out_drive         <= drive;
      out_steer         <= steer;
      out_unlock_action <= unlock;
      out_notify        <= notify;
    end
  end

endmodule

// ----- sim/qes_checker.sv -----
// Checker: predicts each quaternion steering result and compares it with the block output.
`timescale 1ns / 1ps
module qes_checker
  import qes_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic [2:0]         in_pose_code,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [4:0]         out_roll_bin,
  input  logic [4:0]         out_pitch_bin,
  input  logic [4:0]         out_yaw_bin,
  input  logic [1:0]         out_drive,
  input  logic [1:0]         out_steer,
  input  logic [1:0]         out_unlock_action,
  input  logic               out_notify,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [4:0]         cfg_data,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);
  localparam int BINS = 18;
  localparam int STEPS = 16;

  typedef struct packed {
    logic [4:0] roll;
    logic [4:0] pitch;
    logic [4:0] yaw;
    logic [1:0] drive;
    logic [1:0] steer;
    logic [1:0] unlock;
    logic       notify;
  } steer_res_t;

  steer_res_t expected_q[$];
  logic [4:0] thr_rl, thr_rh, thr_ll, thr_lh;
  logic [4:0] roll_s, pitch_s, yaw_s;
  logic [2:0] pose_s;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sqrt_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += longint'(atan_units(i[4:0]));
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(atan_units(i[4:0]));
      end
    end
    return z;
  endfunction

  function automatic logic [4:0] angle_bin(longint a, int span);
    longint b;
    if (a <= 0) return 5'd0;
    b = (a * BINS) >>> span;
    if (b > BINS) b = BINS;
    return b[4:0];
  endfunction

  task automatic predict_steering();
    steer_res_t r;
    longint w, x, y, z, rn, rd, yn, yd, s, c, one;
    logic [2:0] p;
    r = '0;
    one = longint'(ONE_Q28);
    if (in_kind == KIND_SAMPLE) begin
      w = in_quat_w; x = in_quat_x; y = in_quat_y; z = in_quat_z;
      rn = 2 * (w * x + y * z);
      rd = one - 2 * (x * x + y * y);
      yn = 2 * (w * z + x * y);
      yd = one - 2 * (y * y + z * z);
      s = 2 * (w * y - z * x);
      if (s > one) s = one;
      if (s < -one) s = -one;
      c = sqrt_floor((64'd1 << 56) - longint'(s * s));
      roll_s = angle_bin(cordic_angle(rn, rd) + longint'(HALF_TURN), 24);
      pitch_s = angle_bin(cordic_angle(s, c) + longint'(QUARTER_TURN), 23);
      yaw_s = angle_bin(cordic_angle(yn, yd) + longint'(HALF_TURN), 24);
    end else if (in_kind == KIND_POSE) begin
      p = (in_pose_code == POSE_INVALID) ? POSE_UNKNOWN : in_pose_code;
      pose_s = p;
      if (p != POSE_REST && p != POSE_UNKNOWN) begin
        r.unlock = UNLOCK_HOLD;
        r.notify = 1'b1;
      end else begin
        r.unlock = UNLOCK_TIMED;
      end
    end else if (in_kind == KIND_UNPAIR) begin
      roll_s = 0; pitch_s = 0; yaw_s = 0;
    end
    if (pose_s == POSE_FIST) r.drive = DRIVE_FORWARD;
    else if (pose_s == POSE_SPREAD || pose_s == POSE_WAVEOUT) r.drive = DRIVE_REVERSE;
    else r.drive = DRIVE_NONE;
    if (yaw_s == 0) r.steer = STEER_STRAIGHT;
    else if (yaw_s > thr_rl && yaw_s < thr_rh) r.steer = STEER_RIGHT;
    else if (yaw_s > thr_ll && yaw_s < thr_lh) r.steer = STEER_LEFT;
    else r.steer = STEER_NONE;
    r.roll = roll_s; r.pitch = pitch_s; r.yaw = yaw_s;
    expected_q.push_back(r);
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    steer_res_t e;
    if (!rst_n) begin
      thr_rl = 5'd12; thr_rh = 5'd16; thr_ll = 5'd0; thr_lh = 5'd5;
      roll_s = 0; pitch_s = 0; yaw_s = 0; pose_s = POSE_UNKNOWN;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RIGHT_LOW:  thr_rl = cfg_data;
          REG_RIGHT_HIGH: thr_rh = cfg_data;
          REG_LEFT_LOW:   thr_ll = cfg_data;
          REG_LEFT_HIGH:  thr_lh = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_roll_bin != e.roll) report("roll_bin", out_roll_bin, e.roll);
          if (out_pitch_bin != e.pitch) report("pitch_bin", out_pitch_bin, e.pitch);
          if (out_yaw_bin != e.yaw) report("yaw_bin", out_yaw_bin, e.yaw);
          if (out_drive != e.drive) report("drive", out_drive, e.drive);
          if (out_steer != e.steer) report("steer", out_steer, e.steer);
          if (out_unlock_action != e.unlock)
            report("unlock_action", out_unlock_action, e.unlock);
          if (out_notify != e.notify) report("notify", out_notify, e.notify);
        end
      end
      if (in_valid && !in_stall) predict_steering();
    end
    pending = expected_q.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
  end
endmodule

// ----- sim/tb.sv -----
// Testbench top: drives requests and threshold writes into the steering block and gives the verdict.
`timescale 1ns / 1ps
module tb
  import qes_pkg::*;
();

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_kind = 0;
  logic signed [15:0] in_quat_w = 0, in_quat_x = 0, in_quat_y = 0, in_quat_z = 0;
  logic [2:0] in_pose_code = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [4:0] out_roll_bin, out_pitch_bin, out_yaw_bin;
  logic [1:0] out_drive, out_steer, out_unlock_action;
  logic out_notify;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [4:0] cfg_data = 0;
  int errors, pending, results_seen;
  int sent;
  int stall_mode;

  always #4 clk = ~clk;

  quaternion_euler_steering u_top (.*);
  qes_checker u_chk (.*);

  // receiver stall pattern: phases of none, light, heavy and periodic stalls
  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((results_seen % 3) == 0) && ($urandom_range(0, 1) == 0);
    endcase
  end

  task automatic write_reg(input logic [2:0] idx, input logic [4:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    @(negedge clk);
  endtask

  // one request; valid held high when the next request follows at once
  task automatic send_req(input logic [1:0] k, input logic signed [15:0] w,
                          input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z, input logic [2:0] p,
                          input bit keep);
    in_valid <= 1'b1;
    in_kind <= k;
    in_quat_w <= w; in_quat_x <= x; in_quat_y <= y; in_quat_z <= z;
    in_pose_code <= p;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
    if (!keep) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic rand_burst(input int n);
    int k;
    logic signed [15:0] c[4];
    real a, b, m;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      for (int j = 0; j < 4; j++) c[j] = rand_comp();
      if (k < 6) begin
        // mostly near-unit quaternions
        if ($urandom_range(0, 3) != 0) begin
          a = 0;
          for (int j = 0; j < 4; j++) a += real'(c[j]) * real'(c[j]);
          if (a > 0) begin
            m = 16384.0 / $sqrt(a);
            for (int j = 0; j < 4; j++) begin
              b = real'(c[j]) * m;
              c[j] = 16'($rtoi(b));
            end
          end
        end
        send_req(KIND_SAMPLE, c[0], c[1], c[2], c[3], 3'($urandom), i != n - 1);
      end else if (k < 8) begin
        send_req(KIND_POSE, c[0], c[1], c[2], c[3], 3'($urandom), i != n - 1);
      end else if (k == 8) begin
        send_req(KIND_UNPAIR, c[0], c[1], c[2], c[3], 3'($urandom), i != n - 1);
      end else begin
        send_req(2'd3, c[0], c[1], c[2], c[3], 3'($urandom), i != n - 1);
      end
    end
  endtask

  function automatic bit write_done_check();
    $display("covered %0d requests, %0d results, six threshold settings", sent, results_seen);
    $display("kinds sample/pose/unpair/other with random receiver stalls");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
    return 1'b1;
  endfunction

  initial begin
    stall_mode = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every kind and pose, zero vector, out-of-range parts
    send_req(KIND_SAMPLE, 0, 0, 0, 0, 0, 0);
    send_req(KIND_SAMPLE, 16384, 0, 0, 0, 0, 0);
    send_req(KIND_SAMPLE, -16384, 0, 0, 0, 0, 0);
    send_req(KIND_SAMPLE, 0, 16384, 0, 0, 0, 0);
    send_req(KIND_SAMPLE, 0, 0, 16384, 0, 0, 0);
    send_req(KIND_SAMPLE, 0, 0, 0, 16384, 0, 0);
    send_req(KIND_SAMPLE, 11585, 0, 11585, 0, 0, 0);
    send_req(KIND_SAMPLE, 11585, 0, -11585, 0, 0, 0);
    send_req(KIND_SAMPLE, 11585, 0, 0, -11585, 0, 0);
    send_req(KIND_SAMPLE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 7, 0);
    send_req(KIND_SAMPLE, -16'sh8000, -16'sh8000, 16'sh7fff, -16'sh8000, 7, 0);
    for (int p = 0; p < 8; p++) send_req(KIND_POSE, 0, 0, 0, 0, 3'(p), p != 7);
    send_req(KIND_UNPAIR, 16'shffff, 0, 0, 0, 7, 0);
    send_req(2'd3, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 7, 0);
    send_req(KIND_POSE, 0, 0, 0, 0, POSE_FIST, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      // threshold settings: reset, extremes, overlap, random
      case (ph)
        0: ;
        1: begin
          write_reg(REG_RIGHT_LOW, 0); write_reg(REG_RIGHT_HIGH, 18);
          write_reg(REG_LEFT_LOW, 0); write_reg(REG_LEFT_HIGH, 18);
        end
        2: begin
          write_reg(REG_RIGHT_LOW, 18); write_reg(REG_RIGHT_HIGH, 0);
          write_reg(REG_LEFT_LOW, 31); write_reg(REG_LEFT_HIGH, 31);
        end
        3: begin
          write_reg(REG_RIGHT_LOW, 8); write_reg(REG_RIGHT_HIGH, 14);
          write_reg(REG_LEFT_LOW, 4); write_reg(REG_LEFT_HIGH, 12);
          write_reg(3'd5, 5'h1f);
        end
        default: begin
          write_reg(REG_RIGHT_LOW, 5'($urandom)); write_reg(REG_RIGHT_HIGH, 5'($urandom));
          write_reg(REG_LEFT_LOW, 5'($urandom)); write_reg(REG_LEFT_HIGH, 5'($urandom));
          write_reg(3'($urandom_range(4, 7)), 5'($urandom));
        end
      endcase
      for (int b = 0; b < 40; b++) begin
        stall_mode = $urandom_range(0, 3);
        rand_burst($urandom_range(1, 8));
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 150)) @(negedge clk);
      end
      drain();
    end
    if (write_done_check()) ;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ----- files.f -----
hw/rtl/qes_pkg.sv
hw/rtl/qes_ctrl.sv
hw/rtl/qes_datapath.sv
hw/rtl/quaternion_euler_steering.sv
sim/qes_checker.sv
sim/tb.sv
